[rtl/core/page_frame_stack_allocator_core_macros.svh]
// assertion macros used by the page frame allocator back end
`ifndef PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PFSA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define PFSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pfsa_pkg.sv]
// shared types and constants of the page frame allocator
package pfsa_pkg;

   localparam int KIND_W   = 2;
   localparam int FRAME_W  = 20;
   localparam int STATUS_W = 3;
   localparam int ALLOC_W  = 15;
   localparam int COUNT_W  = 16;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd4;

   // command queue between front and back, power of two deep
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ALLOC_W-1:0]  alloc_frame;
      logic                is_free;
      logic [COUNT_W-1:0]  free_count;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_TEST,
      OP_RANGE,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_wr_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_rd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

[rtl/core/pfsa_front.sv]
// request intake: decode and range check into a one-entry stage
module pfsa_front #(
   parameter int NUM_FRAMES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pfsa_pkg::req_type req_payload,
   input  logic              clearing,
   input  logic              q_full,
   output pfsa_pkg::q_wr_type q_wr
);
   import pfsa_pkg::*;

   localparam int LIM_W = FRAME_W + 1;
   localparam logic [LIM_W-1:0] FRAME_LIMIT = LIM_W'(NUM_FRAMES);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_ff, stage_in;
   logic    accept;
   logic    push;
   logic    out_of_range;

   assign busy   = clearing || (stage_valid_ff && q_full);
   assign accept = start && !busy;
   assign push   = stage_valid_ff && !q_full;

   assign out_of_range = {1'b0, req_payload.frame} >= FRAME_LIMIT;

   always_comb begin
      stage_in.frame = req_payload.frame;
      case (req_payload.kind)
         KIND_ALLOC: stage_in.op = OP_ALLOC;
         KIND_FREE:  stage_in.op = out_of_range ? OP_RANGE : OP_FREE;
         KIND_TEST:  stage_in.op = out_of_range ? OP_RANGE : OP_TEST;
         default:    stage_in.op = OP_NOP;
      endcase
      stage_valid_in = accept || (stage_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign q_wr.push = push;
   assign q_wr.cmd  = stage_ff;

endmodule

[rtl/core/pfsa_queue.sv]
// small command fifo between front and back
module pfsa_queue (
   input  logic                clock,
   input  logic                reset,
   input  pfsa_pkg::q_wr_type  q_wr,
   input  logic                q_pop,
   output logic                q_full,
   output pfsa_pkg::q_rd_type  q_rd
);
   import pfsa_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_wr.push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({q_wr.push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

   assign q_full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_rd.valid = count_ff != '0;
   assign q_rd.cmd   = entry_ff[rd_ptr_ff];

endmodule

[rtl/core/pfsa_back.sv]
// execution unit: stack and bitmap memories, clear pass, result register
`include "page_frame_stack_allocator_core_macros.svh"

module pfsa_back #(
   parameter int NUM_FRAMES = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  pfsa_pkg::q_rd_type q_rd,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_valid,
   output pfsa_pkg::rsp_type  rsp_payload
);
   import pfsa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int DW = $clog2(NUM_FRAMES + 1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(NUM_FRAMES);
   localparam logic [FW-1:0] CLEAR_LAST = FW'(NUM_FRAMES - 1);

   logic [FW-1:0] stack_mem_ff [NUM_FRAMES];
   logic          map_mem_ff [NUM_FRAMES];

   back_state_type state_ff, state_in;
   logic [FW-1:0]  clr_idx_ff, clr_idx_in;
   logic [DW-1:0]  depth_ff, depth_in;
   cmd_type        cmd_ff, cmd_in;
   logic [FW-1:0]  stack_rd_ff;
   logic           map_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [DW-1:0]       depth_dec;
   logic                rd_en;
   logic                map_we;
   logic [FW-1:0]       map_waddr;
   logic                map_wdata;
   logic                stk_we;
   logic [FW-1:0]       stk_wdata;
   logic [STATUS_W-1:0] status;
   logic [FW-1:0]       given;
   logic                bit_out;

   assign depth_dec = depth_ff - DW'(1);

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      depth_in     = depth_ff;
      cmd_in       = cmd_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      map_we       = 1'b0;
      map_waddr    = clr_idx_ff;
      map_wdata    = 1'b0;
      stk_we       = 1'b0;
      stk_wdata    = cmd_ff.frame[FW-1:0];
      status       = ST_OK;
      given        = '0;
      bit_out      = 1'b0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            map_we     = 1'b1;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == CLEAR_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_rd.valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_rd.cmd;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = BK_IDLE;
            case (cmd_ff.op)
               OP_ALLOC: begin
                  if (depth_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     depth_in  = depth_dec;
                     given     = stack_rd_ff;
                     map_we    = 1'b1;
                     map_waddr = stack_rd_ff;
                  end
               end
               OP_FREE: begin
                  if (map_rd_ff) begin
                     status = ST_DOUBLE;
                  end else if (depth_ff >= DEPTH_MAX) begin
                     status = ST_FULL;
                  end else begin
                     stk_we    = 1'b1;
                     depth_in  = depth_ff + DW'(1);
                     map_we    = 1'b1;
                     map_waddr = cmd_ff.frame[FW-1:0];
                     map_wdata = 1'b1;
                  end
               end
               OP_TEST:  bit_out = map_rd_ff;
               OP_RANGE: status  = ST_RANGE;
               default:  status  = ST_OK;
            endcase
         end
         default: state_in = BK_CLEAR;
      endcase
      rsp_in.status      = status;
      rsp_in.alloc_frame = ALLOC_W'(given);
      rsp_in.is_free     = bit_out;
      rsp_in.free_count  = COUNT_W'(depth_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_idx_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // memories: read addresses come from the queue head and the stack top
   always_ff @(posedge clock) begin
      if (rd_en) begin
         stack_rd_ff <= stack_mem_ff[depth_dec[FW-1:0]];
         map_rd_ff   <= map_mem_ff[q_rd.cmd.frame[FW-1:0]];
      end
      if (stk_we) begin
         stack_mem_ff[depth_ff[FW-1:0]] <= stk_wdata;
      end
      if (map_we) begin
         map_mem_ff[map_waddr] <= map_wdata;
      end
   end

   assign clearing    = state_ff == BK_CLEAR;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PFSA_ASSERT_NEXT(a_exec_gives_result, clock, reset, state_ff == BK_EXEC, rsp_valid_ff,
      "execute cycle did not produce a result")
   `PFSA_ASSERT_NOW(a_no_result_in_clear, clock, reset, state_ff == BK_CLEAR,
      !rsp_valid_ff && !q_pop, "activity during bitmap clear")
   `PFSA_ASSERT_NEXT(a_alloc_pops, clock, reset,
      state_ff == BK_EXEC && cmd_ff.op == OP_ALLOC && depth_ff != '0,
      depth_ff + DW'(1) == $past(depth_ff), "allocate did not pop the stack")

endmodule

[rtl/core/page_frame_stack_allocator_core.sv]
// top level of the page frame allocator: front, command queue and back
//
//   channel   ports                          handshake
//   request   start, busy, req_payload       transfer when start and not busy
//   result    rsp_valid, rsp_payload         transfer on every rsp_valid cycle
//
// the back end handles each request in an idle state that reads the stack top and the
// frame's bitmap bit, then an execute state that writes the memories and registers the result
// a request passes the intake stage, the command queue and the back end's execute state
// after reset busy stays high while the bitmap is cleared
// busy also rises when the intake stage and the command queue are both full
// the receiver cannot stall; each result is shown for exactly one cycle
module page_frame_stack_allocator_core #(
   parameter int NUM_FRAMES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pfsa_pkg::req_type req_payload,
   output logic              rsp_valid,
   output pfsa_pkg::rsp_type rsp_payload
);
   import pfsa_pkg::*;

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;
   logic     clearing;

   // decode and range check of each transfer
   pfsa_front #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_wr        (q_wr)
   );

   // decouples intake from execution
   pfsa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_rd   (q_rd)
   );

   // stack, bitmap and free count live here
   pfsa_back #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_rd        (q_rd),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/tb.sv]
// self-checking testbench for the page frame stack allocator core
`timescale 1ns / 1ps

module tb;
   import pfsa_pkg::*;

   // frame count of the instance under test
   localparam int NUM_FRAMES  = 32768;
   // kind code that the block answers without touching its state
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   // covers the clear pass and about 1600 requests many times over
   localparam int CYCLE_LIMIT = 400000;
   // cycles allowed for stray results once the last expected one is in
   localparam int DRAIN_CYCLES = 12;

   // mirror of the allocator: free stack, free map, count and pending results
   class frame_ledger;
      bit          free_map [NUM_FRAMES];
      bit [14:0]   stack_mem [NUM_FRAMES];
      int          depth;
      int          free_total;
      rsp_type     expected [$];
      int          faults;

      function new();
         depth = 0;
         free_total = 0;
         faults = 0;
         foreach (free_map[i]) free_map[i] = 1'b0;
      endfunction

      // work out the answer to one accepted request and queue it
      function void note_request(req_type r);
         rsp_type ans;
         bit [14:0] popped;
         ans = '0;
         ans.status = ST_OK;
         case (r.kind)
            KIND_ALLOC: begin
               if (depth == 0) begin
                  ans.status = ST_EMPTY;
               end else begin
                  depth--;
                  popped = stack_mem[depth[14:0]];
                  free_map[popped] = 1'b0;
                  if (free_total > 0) free_total--;
                  ans.alloc_frame = popped;
               end
            end
            KIND_FREE: begin
               if (r.frame >= NUM_FRAMES) begin
                  ans.status = ST_RANGE;
               end else if (free_map[r.frame[14:0]]) begin
                  ans.status = ST_DOUBLE;
               end else if (depth >= NUM_FRAMES) begin
                  ans.status = ST_FULL;
               end else begin
                  stack_mem[depth[14:0]] = r.frame[14:0];
                  depth++;
                  free_map[r.frame[14:0]] = 1'b1;
                  free_total++;
               end
            end
            KIND_TEST: begin
               if (r.frame >= NUM_FRAMES) ans.status = ST_RANGE;
               else ans.is_free = free_map[r.frame[14:0]];
            end
            default: begin
            end
         endcase
         ans.free_count = free_total[COUNT_W-1:0];
         expected.push_back(ans);
      endfunction

      // compare one result transfer against the oldest pending answer
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: status %0d frame %0d free %0b count %0d",
                        got.status, got.alloc_frame, got.is_free, got.free_count);
            return;
         end
         want = expected.pop_front();
         if (got.status !== want.status || got.alloc_frame !== want.alloc_frame ||
             got.is_free !== want.is_free || got.free_count !== want.free_count) begin
            faults++;
            if (faults <= 10)
               $display("mismatch: expected status %0d frame %0d free %0b count %0d,",
                        want.status, want.alloc_frame, want.is_free, want.free_count,
                        " got status %0d frame %0d free %0b count %0d",
                        got.status, got.alloc_frame, got.is_free, got.free_count);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;
   int      cycle_count = 0;

   frame_ledger ledger = new();

   page_frame_stack_allocator_core #(
      .NUM_FRAMES(NUM_FRAMES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // monitor: both channels are sampled at the edge, before any update lands
   // a request transfer is start high with busy low; results cannot be held off
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) ledger.note_request(req_payload);
         if (rsp_valid) ledger.check_result(rsp_payload);
      end
   end

   // watchdog: fails the run at CYCLE_LIMIT; the bitmap clear after reset counts toward it
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // present one request and hold it until the transfer edge
   task automatic send(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] frame);
      req_type r;
      r.kind = kind;
      r.frame = frame;
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drop start for the given number of cycles between bursts
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [FRAME_W-1:0] inside_frame();
      return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
   endfunction

   function automatic logic [FRAME_W-1:0] outside_frame();
      return FRAME_W'($urandom_range(NUM_FRAMES, (1 << FRAME_W) - 1));
   endfunction

   // a frame currently on the free stack, or any in-range frame if none
   function automatic logic [FRAME_W-1:0] held_frame();
      logic [14:0] slot;
      if (ledger.depth == 0) return inside_frame();
      slot = 15'($urandom_range(0, ledger.depth - 1));
      return FRAME_W'(ledger.stack_mem[slot]);
   endfunction

   // directed requests: range edges, empty stack, double free, every kind
   task automatic run_directed();
      send(KIND_ALLOC, '0);                   // empty stack
      send(KIND_TEST, 20'd0);
      send(KIND_TEST, 20'd32767);
      send(KIND_TEST, 20'd32768);             // first frame out of range
      send(KIND_TEST, 20'hFFFFF);
      send(KIND_FREE, 20'hFFFFF);             // out of range free
      send(KIND_FREE, 20'd32768);
      send(KIND_FREE, 20'd0);
      send(KIND_FREE, 20'd32767);
      send(KIND_FREE, 20'd0);                 // double free
      send(KIND_TEST, 20'd0);
      send(KIND_FREE, 20'h05555);
      send(KIND_FREE, 20'h02AAA);
      send(KIND_NONE, 20'hFFFFF);             // unused kind
      send(KIND_NONE, 20'd0);
      send(KIND_ALLOC, 20'hFFFFF);            // frame field ignored on allocate
      send(KIND_ALLOC, 20'd0);
      send(KIND_ALLOC, 20'h2AAAA);
      send(KIND_ALLOC, 20'd0);
      send(KIND_ALLOC, 20'd0);                // empty again
      send(KIND_TEST, 20'd32767);
      send(KIND_FREE, 20'd32767);             // refill after drain
      pause(3);
   endtask

   // random requests in bursts; phases alternate between filling and draining
   task automatic run_random(input int count);
      int left;
      int burst;
      int phase_left;
      int roll;
      int pick;
      bit filling;
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      left = count;
      filling = 1'b1;
      phase_left = $urandom_range(100, 300);
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            frame = FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1));
            if (roll < (filling ? 25 : 50)) begin
               kind = KIND_ALLOC;
            end else if (roll < 80) begin
               kind = KIND_FREE;
               if (pick < 2) frame = held_frame();      // double free
               else if (pick < 3) frame = outside_frame();
               else frame = inside_frame();
            end else if (roll < 95) begin
               kind = KIND_TEST;
               if (pick < 4) frame = held_frame();
               else if (pick < 6) frame = outside_frame();
               else frame = inside_frame();
            end else begin
               kind = KIND_NONE;
            end
            send(kind, frame);
            left--;
            phase_left--;
            if (phase_left == 0) begin
               filling = !filling;
               phase_left = $urandom_range(100, 300);
            end
         end
         // about a quarter of bursts run straight into the next one
         pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      start <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(1600);
      // wait for every answer, then watch for stray results
      while (ledger.expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.faults == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
